>>> rtl/som_best_matching_unit_core_macros.svh
// Assertion macros shared by the best-matching-unit checker.
`ifndef SOM_BEST_MATCHING_UNIT_CORE_MACROS_SVH
`define SOM_BEST_MATCHING_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBMU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbmu_pkg.sv
// Shared types and constants of the best-matching-unit search block.
`timescale 1ns / 1ps

package sbmu_pkg;

    localparam int DIST_W = 48;
    localparam int SQ_W   = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/sbmu_divider.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module sbmu_divider #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic [NUM_W-1:0]     quot,
    output sbmu_pkg::div_status_t status
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             qbit;
    logic [DEN_W-1:0] rem_next;

    assign rem_sh   = {rem_reg, quot_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign qbit     = (rem_sh >= {1'b0, den_reg});
    assign rem_next = qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out at the top while quotient bits enter at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[NUM_W-2:0], qbit};
            rem_reg  <= rem_next;
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/som_best_matching_unit_core.sv
// Self-organizing-map best-matching-unit search core with on-chip codebook.
// The block holds a codebook of MAX_UNITS x MAX_FEATURES signed values and
// finds, for one query object, the nearest unit by squared Euclidean distance
// over the features that are present. Command 0 writes one codebook element;
// command 1 delivers one query feature (value plus missing flag). The delivery
// flagged last_feature starts a search, during which s_ready is low: a
// counting pass runs over the missing flags (p = features in use), each unit
// then passes through the one-product-per-cycle multiply-accumulate pipeline,
// and a unit whose raw sum beats the best so far is additionally scaled by
// p/(p-missing) in the bit-serial divider. The sum of a unit is scaled as
// floor(sum*p/(p-missing)), the strictly smallest scaled distance wins so the
// lowest index wins ties, and the result is one transaction of found,
// best_unit and best_distance (unsigned Q48.0, saturating at 2^48-1).
// With every feature missing the result is found = 0 with zero unit and
// distance. The missing flags return to all-missing after each search. A
// finished result waits in an output register; codebook writes and feature
// deliveries are taken meanwhile, and the next search holds its result until
// the register is free. There is no clearing pass after reset; an unwritten
// codebook entry reads as anything.
`timescale 1ns / 1ps

module som_best_matching_unit_core #(
    parameter int MAX_UNITS    = 64,
    parameter int MAX_FEATURES = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [5:0]         s_unit_index,
    input  logic [3:0]         s_feature_index,
    input  logic signed [15:0] s_feature_value,
    input  logic               s_feature_missing,
    input  logic               s_last_feature,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [5:0]         m_best_unit,
    output logic [47:0]        m_best_distance,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DIST_W   = sbmu_pkg::DIST_W;
    localparam int SQ_W     = sbmu_pkg::SQ_W;
    localparam int VW       = VALUE_WIDTH;
    localparam int DW       = VALUE_WIDTH + 1;
    localparam int UW       = $clog2(MAX_UNITS + 1);
    localparam int PW       = $clog2(MAX_FEATURES + 1);
    localparam int FIDX_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CB_DEPTH = MAX_UNITS * MAX_FEATURES;
    localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
    localparam int XW       = DIST_W + PW;

    localparam logic REG_UNITS_IN_USE    = 1'b0;
    localparam logic REG_FEATURES_IN_USE = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_COUNT  = 10'b00_0000_0010,
        ST_ACCUM  = 10'b00_0000_0100,
        ST_NEXT   = 10'b00_0000_1000,
        ST_MUL_LO = 10'b00_0001_0000,
        ST_MUL_HI = 10'b00_0010_0000,
        ST_DIV_GO = 10'b00_0100_0000,
        ST_DIVIDE = 10'b00_1000_0000,
        ST_UPDATE = 10'b01_0000_0000,
        ST_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    // Configuration registers and their clamped working values.
    logic [6:0]    units_in_use_reg;
    logic [4:0]    features_in_use_reg;
    logic [UW-1:0] units_eff;
    logic [PW-1:0] feats_eff;

    // Query store: values in a small memory, missing flags in flip-flops.
    logic signed [VW-1:0] qv_mem [MAX_FEATURES];
    logic signed [VW-1:0] cb_mem [CB_DEPTH];
    logic [MAX_FEATURES-1:0] mask_reg;

    // Sequencer counters.
    logic [PW-1:0]    j_reg;
    logic [PW-1:0]    na_reg;
    logic [UW-1:0]    unit_reg;
    logic [CB_AW-1:0] base_reg;
    logic             found_reg;
    logic [FIDX_W-1:0] j_idx;

    // Input decode.
    logic              accept;
    logic              feat_in_range;
    logic              unit_in_range;
    logic              cb_we;
    logic              qv_we;
    logic              start_search;
    logic [FIDX_W-1:0] in_fidx;
    logic [CB_AW-1:0]  cb_wr_addr;
    logic [CB_AW-1:0]  cb_rd_addr;
    logic signed [VW-1:0] value_in;

    // Multiply-accumulate pipeline.
    logic                 issue;
    logic                 pipe_empty;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic signed [VW-1:0] cb_rd_reg;
    logic signed [VW-1:0] qv_rd_reg;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic                 sat2_reg;
    logic [SQ_W-1:0]      mag2_reg;
    logic [DIST_W-1:0]    sq3_reg;
    logic [SQ_W-1:0]      mul_a;
    logic [SQ_W-1:0]      mul_b;
    logic [DIST_W-1:0]    mul_p;
    logic [DIST_W:0]      sum_add;
    logic [DIST_W-1:0]    sum_next;
    logic [DIST_W-1:0]    sum_reg;

    // Scaling and best tracking.
    logic [XW-1:0]     prod_x_reg;
    logic [PW-1:0]     q_reg;
    logic [XW-1:0]     div_quot;
    logic [DIST_W-1:0] scaled_d;
    logic [DIST_W-1:0] best_sum_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [5:0]        best_unit_reg;
    logic              candidate;
    logic              last_unit;
    logic              slot_free;
    sbmu_pkg::div_status_t div_status;

    // Result register.
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [5:0]        m_best_unit_reg;
    logic [DIST_W-1:0] m_best_distance_reg;

    logic cfg_wr;

    // Clamp register values to the range the storage supports.
    always_comb begin
        if (units_in_use_reg == '0) begin
            units_eff = UW'(1);
        end else if (int'(units_in_use_reg) > MAX_UNITS) begin
            units_eff = UW'(MAX_UNITS);
        end else begin
            units_eff = UW'(units_in_use_reg);
        end
        if (features_in_use_reg == '0) begin
            feats_eff = PW'(1);
        end else if (int'(features_in_use_reg) > MAX_FEATURES) begin
            feats_eff = PW'(MAX_FEATURES);
        end else begin
            feats_eff = PW'(features_in_use_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign feat_in_range = (int'(s_feature_index) < MAX_FEATURES);
    assign unit_in_range = (int'(s_unit_index) < MAX_UNITS);
    assign in_fidx       = FIDX_W'(s_feature_index);
    assign value_in      = VW'(s_feature_value);
    assign cb_wr_addr    = CB_AW'(s_unit_index) * CB_AW'(MAX_FEATURES)
                         + CB_AW'(s_feature_index);

    assign cb_we = accept && (s_command == sbmu_pkg::CMD_WRITE)
                && unit_in_range && feat_in_range;
    assign qv_we = accept && (s_command == sbmu_pkg::CMD_QUERY) && feat_in_range;
    assign start_search = accept && (s_command == sbmu_pkg::CMD_QUERY) && s_last_feature;

    assign j_idx      = j_reg[FIDX_W-1:0];
    assign cb_rd_addr = base_reg + CB_AW'(j_reg);

    // Feed a feature into the pipeline only when it is present.
    assign issue      = (state_reg == ST_ACCUM) && (j_reg != feats_eff) && !mask_reg[j_idx];
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    assign candidate = (unit_reg == '0) || (sum_reg < best_sum_reg);
    assign last_unit = (unit_reg == units_eff - UW'(1));
    assign slot_free = !m_valid_reg || m_ready;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_UNITS_IN_USE:    prdata = 32'(units_in_use_reg);
            REG_FEATURES_IN_USE: prdata = 32'(features_in_use_reg);
            default:             prdata = '0;
        endcase
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            units_in_use_reg    <= 7'd64;
            features_in_use_reg <= 5'd16;
            mask_reg            <= '1;
            j_reg               <= '0;
            na_reg              <= '0;
            unit_reg            <= '0;
            base_reg            <= '0;
            found_reg           <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_UNITS_IN_USE:    units_in_use_reg    <= pwdata[6:0];
                    REG_FEATURES_IN_USE: features_in_use_reg <= pwdata[4:0];
                    default: ;
                endcase
            end

            // Load a finished result when the register is free; drop it once taken.
            if ((state_reg == ST_EMIT) && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (qv_we) begin
                        mask_reg[in_fidx] <= s_feature_missing;
                    end
                    if (start_search) begin
                        j_reg     <= '0;
                        na_reg    <= '0;
                        state_reg <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    if (j_reg != feats_eff) begin
                        na_reg <= na_reg + PW'(mask_reg[j_idx]);
                        j_reg  <= j_reg + PW'(1);
                    end else if (na_reg == feats_eff) begin
                        found_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else begin
                        found_reg <= 1'b1;
                        unit_reg  <= '0;
                        base_reg  <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (j_reg != feats_eff) begin
                        j_reg <= j_reg + PW'(1);
                    end else if (pipe_empty) begin
                        state_reg <= candidate ? ST_MUL_LO : ST_NEXT;
                    end
                end
                ST_MUL_LO: state_reg <= ST_MUL_HI;
                ST_MUL_HI: state_reg <= ST_DIV_GO;
                ST_DIV_GO: state_reg <= ST_DIVIDE;
                ST_DIVIDE: begin
                    if (div_status.done) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: state_reg <= ST_NEXT;
                ST_NEXT: begin
                    if (last_unit) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        unit_reg  <= unit_reg + UW'(1);
                        base_reg  <= base_reg + CB_AW'(MAX_FEATURES);
                        j_reg     <= '0;
                        state_reg <= ST_ACCUM;
                    end
                end
                ST_EMIT: begin
                    // Hold until the result register is free, then reset the query.
                    if (slot_free) begin
                        mask_reg  <= '1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Memories: one write port from the input channel, one registered read.
    always_ff @(posedge aclk) begin
        if (cb_we) begin
            cb_mem[cb_wr_addr] <= value_in;
        end
        cb_rd_reg <= cb_mem[cb_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (qv_we) begin
            qv_mem[in_fidx] <= value_in;
        end
        qv_rd_reg <= qv_mem[j_idx];
    end

    // Difference magnitude; anything at or above 2^24 squares to saturation.
    assign diff = DW'(qv_rd_reg) - DW'(cb_rd_reg);
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

    // One multiplier serves the squares and the two halves of sum * p.
    always_comb begin
        case (state_reg)
            ST_MUL_LO: begin
                mul_a = sum_reg[SQ_W-1:0];
                mul_b = SQ_W'(feats_eff);
            end
            ST_MUL_HI: begin
                mul_a = sum_reg[DIST_W-1:SQ_W];
                mul_b = SQ_W'(feats_eff);
            end
            default: begin
                mul_a = mag2_reg;
                mul_b = mag2_reg;
            end
        endcase
    end

    assign mul_p = DIST_W'(mul_a) * DIST_W'(mul_b);

    assign sum_add  = {1'b0, sum_reg} + {1'b0, sq3_reg};
    assign sum_next = sum_add[DIST_W] ? sbmu_pkg::DIST_MAX : sum_add[DIST_W-1:0];

    assign scaled_d = (|div_quot[XW-1:DIST_W]) ? sbmu_pkg::DIST_MAX
                                               : div_quot[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sat2_reg <= |(mag >> SQ_W);
        mag2_reg <= SQ_W'(mag);
        sq3_reg  <= sat2_reg ? sbmu_pkg::DIST_MAX : mul_p;

        case (state_reg)
            ST_COUNT: begin
                sum_reg       <= '0;
                q_reg         <= feats_eff - na_reg;
                best_d_reg    <= '0;
                best_unit_reg <= '0;
            end
            ST_ACCUM: begin
                if (v3_reg) begin
                    sum_reg <= sum_next;
                end
            end
            ST_MUL_LO: prod_x_reg <= XW'(mul_p);
            ST_MUL_HI: prod_x_reg <= prod_x_reg + (XW'(mul_p) << SQ_W);
            ST_UPDATE: begin
                if ((unit_reg == '0) || (scaled_d < best_d_reg)) begin
                    best_d_reg    <= scaled_d;
                    best_unit_reg <= 6'(unit_reg);
                    best_sum_reg  <= sum_reg;
                end
            end
            ST_NEXT: sum_reg <= '0;
            ST_EMIT: begin
                if (slot_free) begin
                    m_found_reg         <= found_reg;
                    m_best_unit_reg     <= best_unit_reg;
                    m_best_distance_reg <= best_d_reg;
                end
            end
            default: ;
        endcase
    end

    sbmu_divider #(
        .NUM_W (XW),
        .DEN_W (PW)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIV_GO),
        .num     (prod_x_reg),
        .den     (q_reg),
        .quot    (div_quot),
        .status  (div_status)
    );

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_best_unit     = m_best_unit_reg;
    assign m_best_distance = m_best_distance_reg;

endmodule

>>> rtl/sbmu_checker.sv
// Port-level checker for the best-matching-unit core, bound to the top level.
`timescale 1ns / 1ps
`include "som_best_matching_unit_core_macros.svh"

module sbmu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_command,
    input logic        s_last_feature,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [5:0]  m_best_unit,
    input logic [47:0] m_best_distance
);

    // A stalled result transaction keeps its payload.
    `SBMU_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_best_unit) && $stable(m_best_distance), "result changed while stalled")

    // An empty query reports zero unit and distance.
    `SBMU_ASSERT_NOW(a_not_found_zero, aclk, aresetn, m_valid && !m_found, m_best_unit == 6'd0 && m_best_distance == 48'd0, "not-found result carries data")

    // The last query feature starts a search that blocks the input.
    `SBMU_ASSERT_NEXT(a_search_blocks, aclk, aresetn, s_valid && s_ready && s_command == sbmu_pkg::CMD_QUERY && s_last_feature, !s_ready, "input ready right after search start")

    // Codebook writes and plain feature deliveries keep the input open.
    `SBMU_ASSERT_NEXT(a_plain_stays_ready, aclk, aresetn, s_valid && s_ready && !(s_command == sbmu_pkg::CMD_QUERY && s_last_feature), s_ready, "input closed after a plain transaction")

    // A new result only appears at the end of a search.
    `SBMU_ASSERT_NOW(a_result_from_search, aclk, aresetn, $rose(m_valid), $past(!s_ready), "result appeared outside a search")

endmodule

bind som_best_matching_unit_core sbmu_checker u_sbmu_checker (.*);

>>> bench/bmu_result_checker.sv
// Checker for the best-matching-unit search: predicts each search result and compares it.
`timescale 1ns / 1ps

module bmu_result_checker #(
    parameter logic [2:0] UNITS_ADDR    = 3'd0,
    parameter logic [2:0] FEATURES_ADDR = 3'd4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_command,
    input  logic [5:0]         s_unit_index,
    input  logic [3:0]         s_feature_index,
    input  logic signed [15:0] s_feature_value,
    input  logic               s_feature_missing,
    input  logic               s_last_feature,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_found,
    input  logic [5:0]         m_best_unit,
    input  logic [47:0]        m_best_distance,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 results_awaited
);

    localparam int UNITS_MAX    = 64;
    localparam int FEATURES_MAX = 16;

    typedef struct packed {
        logic                        found;
        logic [5:0]                  best_unit;
        logic [sbmu_pkg::DIST_W-1:0] distance;
    } bmu_result_t;

    logic signed [15:0] cb_mem [UNITS_MAX][FEATURES_MAX];
    logic signed [15:0] query_val [FEATURES_MAX];
    logic [FEATURES_MAX-1:0] absent;
    logic [6:0] units_reg;
    logic [4:0] feats_reg;
    bmu_result_t awaited_results [$];
    int errors = 0;

    function automatic int clamp_count(input int n, input int top);
        if (n < 1) return 1;
        return (n > top) ? top : n;
    endfunction

    // Nearest unit over the present features, sum scaled by p/(p-missing).
    function automatic bmu_result_t nearest_unit_search();
        int p;
        int n_units;
        int n_absent;
        logic [63:0] sum;
        logic [63:0] best_sum;
        logic signed [16:0] diff;
        logic [16:0] mag;
        bmu_result_t res;
        p        = clamp_count(int'(feats_reg), FEATURES_MAX);
        n_units  = clamp_count(int'(units_reg), UNITS_MAX);
        n_absent = 0;
        res      = '0;
        best_sum = '0;
        for (int j = 0; j < p; j++)
            if (absent[j]) n_absent++;
        if (n_absent == p) return res;
        for (int u = 0; u < n_units; u++) begin
            sum = '0;
            for (int j = 0; j < p; j++) begin
                if (!absent[j]) begin
                    diff = {query_val[j][15], query_val[j]} - {cb_mem[u][j][15], cb_mem[u][j]};
                    mag  = diff[16] ? 17'(-diff) : 17'(diff);
                    sum  = sum + 64'(mag) * 64'(mag);
                    if (sum > 64'(sbmu_pkg::DIST_MAX)) sum = 64'(sbmu_pkg::DIST_MAX);
                end
            end
            sum = (sum * 64'(p)) / 64'(p - n_absent);
            if (sum > 64'(sbmu_pkg::DIST_MAX)) sum = 64'(sbmu_pkg::DIST_MAX);
            if (u == 0 || sum < best_sum) begin
                best_sum      = sum;
                res.best_unit = 6'(u);
            end
        end
        res.found    = 1'b1;
        res.distance = best_sum[sbmu_pkg::DIST_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        bmu_result_t want;
        if (!aresetn) begin
            units_reg = 7'd64;
            feats_reg = 5'd16;
            absent    = '1;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == UNITS_ADDR)
                    units_reg = pwdata[6:0];
                else if (paddr == FEATURES_ADDR)
                    feats_reg = pwdata[4:0];
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: found %0d, best_unit %0d, best_distance %0d",
                           m_found, m_best_unit, m_best_distance);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_found);
                        errors++;
                    end
                    if (m_best_unit !== want.best_unit) begin
                        $error("best_unit: expected %0d, got %0d", want.best_unit, m_best_unit);
                        errors++;
                    end
                    if (m_best_distance !== want.distance) begin
                        $error("best_distance: expected %0d, got %0d",
                               want.distance, m_best_distance);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (sbmu_pkg::cmd_t'(s_command) == sbmu_pkg::CMD_WRITE) begin
                    cb_mem[s_unit_index][s_feature_index] = s_feature_value;
                end else begin
                    query_val[s_feature_index] = s_feature_value;
                    absent[s_feature_index]    = s_feature_missing;
                    if (s_last_feature) begin
                        awaited_results.push_back(nearest_unit_search());
                        absent = '1;
                    end
                end
            end
        end
        mismatch_count  <= errors;
        results_awaited <= awaited_results.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the best-matching-unit testbench: clock, reset, stimulus, register writes, verdict.
`timescale 1ns / 1ps

module testbench;

    // Register map: units_in_use first, features_in_use second, 4 bytes apart.
    localparam logic [2:0] UNITS_REG    = 3'd0;
    localparam logic [2:0] FEATURES_REG = 3'd4;

    // Give up after this many cycles without a single transaction on any port.
    // The slowest legal quiet stretch is a 64-unit search where every unit
    // improves on the best, overlapping a long receiver hold.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int LONG_HOLD      = 2000;

    // Codebook rows for the directed part; unit 1 repeats unit 0 to force a tie.
    localparam logic [3:0][15:0] ROW_A = {16'h0001, 16'h0000, 16'h7FFF, 16'h8000};
    localparam logic [3:0][15:0] ROW_C = {16'hFF00, 16'h0100, 16'h8000, 16'h7FFF};

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [5:0]         s_unit_index;
    logic [3:0]         s_feature_index;
    logic signed [15:0] s_feature_value;
    logic               s_feature_missing;
    logic               s_last_feature;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;
    logic [5:0]         m_best_unit;
    logic [47:0]        m_best_distance;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int mismatch_count;
    int results_awaited;

    // Stimulus-side bookkeeping: effective sizes and which codebook cells hold
    // data, so that no search ever reads a cell that was never written.
    int units_now;
    int feats_now;
    int items_sent = 0;
    int idle_cycles = 0;
    bit cb_known [64][16];
    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;
    bit long_hold_req  = 1'b0;

    always #10 aclk = ~aclk;

    som_best_matching_unit_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_unit_index      (s_unit_index),
        .s_feature_index   (s_feature_index),
        .s_feature_value   (s_feature_value),
        .s_feature_missing (s_feature_missing),
        .s_last_feature    (s_last_feature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_best_unit       (m_best_unit),
        .m_best_distance   (m_best_distance),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    bmu_result_checker #(
        .UNITS_ADDR    (UNITS_REG),
        .FEATURES_ADDR (FEATURES_REG)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_unit_index      (s_unit_index),
        .s_feature_index   (s_feature_index),
        .s_feature_value   (s_feature_value),
        .s_feature_missing (s_feature_missing),
        .s_last_feature    (s_last_feature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_best_unit       (m_best_unit),
        .m_best_distance   (m_best_distance),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .mismatch_count    (mismatch_count),
        .results_awaited   (results_awaited)
    );

    // Watchdog: count cycles in which no transaction completes anywhere.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: mostly ready, short stalls now and then, an occasional long
    // one, and a single very long hold when the stimulus asks for it.
    initial begin
        int hold;
        int r;
        hold = 0;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold == 0 && recv_stalls_on) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    hold = $urandom_range(1, 3);
                else if (r < 14)
                    hold = $urandom_range(15, 60);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    function automatic int sender_gap();
        int r;
        if (!send_gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor the extremes and values near zero; near-zero values make ties likely.
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transaction on the input channel and hold it until accepted.
    // Lower valid only when a gap is wanted, so back-to-back items keep it high.
    task automatic send_item(input sbmu_pkg::cmd_t cmd, input int unit_idx,
                             input int feat_idx, input logic signed [15:0] value,
                             input bit missing, input bit last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_unit_index      <= 6'(unit_idx);
        s_feature_index   <= 4'(feat_idx);
        s_feature_value   <= value;
        s_feature_missing <= missing;
        s_last_feature    <= last;
        do @(posedge aclk); while (!s_ready);
        if (cmd == sbmu_pkg::CMD_WRITE) cb_known[unit_idx][feat_idx] = 1'b1;
        items_sent++;
    endtask

    // Setup phase, access phase, then an idle gap with psel low so writes never abut.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Raw values may lie outside 1..max; the block saturates them on use.
    task automatic set_config(input int units_raw, input int feats_raw);
        reg_write(UNITS_REG, 32'(units_raw));
        reg_write(FEATURES_REG, 32'(feats_raw));
        units_now = (units_raw < 1) ? 1 : ((units_raw > 64) ? 64 : units_raw);
        feats_now = (feats_raw < 1) ? 1 : ((feats_raw > 16) ? 16 : feats_raw);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic await_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_awaited != 0);
    endtask

    // Write every cell the current search size can read that has no data yet.
    task automatic fill_codebook();
        for (int u = 0; u < units_now; u++)
            for (int j = 0; j < feats_now; j++)
                if (!cb_known[u][j])
                    send_item(sbmu_pkg::CMD_WRITE, u, j, pick_value(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // One well-formed query object: every feature in use, rotated start,
    // a few missing (rarely all), last on the final delivery. Now and then
    // slip in a stray delivery, often beyond the features in use.
    task automatic send_query_object();
        int start;
        int j;
        bit all_absent;
        all_absent = ($urandom_range(0, 11) == 0);
        start      = $urandom_range(0, feats_now - 1);
        for (int k = 0; k < feats_now; k++) begin
            j = (start + k) % feats_now;
            if ($urandom_range(0, 9) == 0)
                send_item(sbmu_pkg::CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                          pick_value(), 1'($urandom_range(0, 1)), 1'b0);
            send_item(sbmu_pkg::CMD_QUERY, $urandom_range(0, 63), j, pick_value(),
                      all_absent || ($urandom_range(0, 6) == 0), k == feats_now - 1);
        end
    endtask

    // Random mix: mostly query objects, then codebook rewrites, then noise.
    task automatic run_mix(input int n);
        int stop;
        int r;
        stop = items_sent + n;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_query_object();
            else if (r < 80)
                send_item(sbmu_pkg::CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 15),
                          pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_item(sbmu_pkg::CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                          pick_value(), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0);
        end
    endtask

    // Quiesce, reconfigure, make the searched region readable, then run.
    task automatic run_phase(input int units_raw, input int feats_raw, input int n,
                             input bit gaps, input bit stalls, input bit hold_long,
                             input bit pause_mid);
        await_results();
        repeat (8) @(posedge aclk);
        send_gaps_on   = gaps;
        recv_stalls_on = stalls;
        set_config(units_raw, feats_raw);
        fill_codebook();
        // Hold the receiver off while the sender keeps going, so the output
        // register fills and the next search stalls the input channel.
        if (hold_long) long_hold_req = 1'b1;
        run_mix(n / 2);
        // Let the sender sit until every search has reported.
        if (pause_mid) await_results();
        run_mix(n - n / 2);
    endtask

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_command         <= sbmu_pkg::CMD_WRITE;
        s_unit_index      <= '0;
        s_feature_index   <= '0;
        s_feature_value   <= '0;
        s_feature_missing <= 1'b0;
        s_last_feature    <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: three units of four features.
        set_config(3, 4);
        for (int u = 0; u < 3; u++)
            for (int j = 0; j < 4; j++)
                send_item(sbmu_pkg::CMD_WRITE, u, j, (u == 2) ? ROW_C[j] : ROW_A[j],
                          1'b0, 1'b0);
        // A write carrying last must not start a search; top unit, top feature.
        send_item(sbmu_pkg::CMD_WRITE, 63, 15, 16'sh1234, 1'b1, 1'b1);
        // Partial query: features 1 and 2 missing, feature 15 beyond the size in
        // use, extremes on both sides of the difference.
        send_item(sbmu_pkg::CMD_QUERY, 0, 0, 16'sh7FFF, 1'b0, 1'b0);
        send_item(sbmu_pkg::CMD_QUERY, 63, 1, 16'sh0000, 1'b1, 1'b0);
        send_item(sbmu_pkg::CMD_QUERY, 0, 15, 16'sh8000, 1'b0, 1'b0);
        send_item(sbmu_pkg::CMD_QUERY, 0, 3, 16'sh8000, 1'b0, 1'b1);
        // Every feature missing: result reports nothing found.
        send_item(sbmu_pkg::CMD_QUERY, 0, 2, 16'sh0000, 1'b1, 1'b1);
        // One feature present, scaled by four; units 0 and 1 tie at zero.
        send_item(sbmu_pkg::CMD_QUERY, 0, 0, 16'sh8000, 1'b0, 1'b1);
        // Full query matching unit 2 exactly, so the winner is not unit 0.
        for (int j = 0; j < 4; j++)
            send_item(sbmu_pkg::CMD_QUERY, 5, j, ROW_C[j], 1'b0, j == 3);

        // Random part over several sizes, the extremes and out-of-range values.
        run_phase(1, 16, 60, 1'b1, 1'b1, 1'b0, 1'b0);
        run_phase(64, 1, 60, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(0, 0, 40, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(127, 1, 80, 1'b1, 1'b1, 1'b0, 1'b1);
        repeat (3)
            run_phase($urandom_range(2, 8), $urandom_range(2, 6), 60, 1'b1, 1'b1, 1'b0, 1'b0);
        run_phase(2, 31, 40, 1'b1, 1'b0, 1'b0, 1'b0);

        // Drain, then give a late stray result time to show up.
        await_results();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && results_awaited == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sbmu_pkg.sv
rtl/sbmu_divider.sv
rtl/som_best_matching_unit_core.sv
rtl/sbmu_checker.sv
bench/bmu_result_checker.sv
bench/testbench.sv
